// File: hdl/bbmq_pkg.sv
// Package for the Bellman backup min-Q block: payload structs, controller
// state and command/status types, register indexes and fixed constants.
// No dependencies.
package bbmq_pkg;

   localparam int MAX_ACTIONS = 16;

   localparam int VALUE_W = 32;
   localparam int PROB_W = 17;
   localparam int ACT_W = 4;
   localparam int SUM_W = 52;
   localparam int PROD_W = PROB_W + VALUE_W;
   localparam int FRAC_W = 16;
   localparam int SCALED_W = SUM_W - FRAC_W + PROB_W - FRAC_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);
   localparam logic [VALUE_W-1:0] DISCOUNT_RESET = VALUE_W'(65536);
   localparam logic [VALUE_W-1:0] DEAD_END_LIMIT_RESET = VALUE_W'(65536000);

   localparam logic [CSR_INDEX_W-1:0] CSR_DISCOUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_END_LIMIT = 1'b1;

   typedef struct packed {
      logic [ACT_W-1:0]   action_index;
      logic               applicable;
      logic [PROB_W-1:0]  succ_prob;
      logic [VALUE_W-1:0] succ_value;
      logic [VALUE_W-1:0] step_cost;
      logic               last_successor;
      logic               last_action;
      logic               is_goal;
      logic [VALUE_W-1:0] old_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] best_value;
      logic [ACT_W-1:0]   best_action;
      logic               has_action;
      logic               dead_end;
      logic [VALUE_W-1:0] residual;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_ACC,
      ST_MUL2,
      ST_QUPD,
      ST_BEST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic ld_item;
      logic mul1;
      logic acc;
      logic mul2;
      logic qupd;
      logic best;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic qual;
      logic last_succ;
      logic last_act;
      logic out_free;
   } status_type;

endpackage

// File: hdl/bbmq_ctrl.sv
// Sequencer of the Bellman backup min-Q block.
// Depends on bbmq_pkg; drives commands into bbmq_dp and reads its status.
module bbmq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bbmq_pkg::status_type status,
   output bbmq_pkg::cmd_type    cmd
);

   bbmq_pkg::state_type state_ff;
   bbmq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbmq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         bbmq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.ld_item = 1'b1;
               state_in = bbmq_pkg::ST_MUL1;
            end
         end
         bbmq_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = bbmq_pkg::ST_ACC;
         end
         bbmq_pkg::ST_ACC: begin
            cmd.acc = status.qual;
            if (status.qual && status.last_succ) begin
               state_in = bbmq_pkg::ST_MUL2;
            end else if (status.last_act) begin
               state_in = bbmq_pkg::ST_BEST;
            end else begin
               state_in = bbmq_pkg::ST_IDLE;
            end
         end
         bbmq_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = bbmq_pkg::ST_QUPD;
         end
         bbmq_pkg::ST_QUPD: begin
            cmd.qupd = 1'b1;
            state_in = status.last_act ? bbmq_pkg::ST_BEST : bbmq_pkg::ST_IDLE;
         end
         bbmq_pkg::ST_BEST: begin
            cmd.best = 1'b1;
            state_in = bbmq_pkg::ST_EMIT;
         end
         bbmq_pkg::ST_EMIT: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = bbmq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bbmq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/bbmq_dp.sv
// Datapath of the Bellman backup min-Q block: item register, multipliers,
// accumulator, running minimum, configuration and result register.
// Depends on bbmq_pkg; sequenced by bbmq_ctrl.
module bbmq_dp #(
   parameter int MAX_ACTIONS = bbmq_pkg::MAX_ACTIONS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bbmq_pkg::req_type                      req_data,
   output bbmq_pkg::rsp_type                      rsp_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic                                   csr_we,
   input  logic [bbmq_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bbmq_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  bbmq_pkg::cmd_type                      cmd,
   output bbmq_pkg::status_type                   status
);

   localparam int VW = bbmq_pkg::VALUE_W;
   localparam int PW = bbmq_pkg::PROB_W;
   localparam int AW = bbmq_pkg::ACT_W;
   localparam int SW = bbmq_pkg::SUM_W;
   localparam int FW = bbmq_pkg::FRAC_W;
   localparam int MW = bbmq_pkg::PROD_W;
   localparam int QW = bbmq_pkg::SCALED_W;
   localparam int MUL2_W = SW - FW + PW;
   localparam int CMP_IDX_W = 9;

   bbmq_pkg::req_type item_ff, item_in;
   bbmq_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]     discount_ff, discount_in;
   logic [VW-1:0]     limit_ff, limit_in;
   logic [MW-1:0]     prod_ff, prod_in;
   logic [SW-1:0]     sum_ff, sum_in;
   logic [QW-1:0]     scaled_ff, scaled_in;
   logic [VW-1:0]     min_ff, min_in;
   logic [AW-1:0]     min_act_ff, min_act_in;
   logic              min_valid_ff, min_valid_in;
   logic              any_appl_ff, any_appl_in;
   logic [VW-1:0]     best_ff, best_in;
   logic [AW-1:0]     best_act_ff, best_act_in;
   logic              has_ff, has_in;
   logic              dead_ff, dead_in;

   logic [SW:0]       sum_ext;
   logic [MUL2_W-1:0] mul2_full;
   logic [QW:0]       q_full;
   logic [VW-1:0]     q_capped;
   logic [VW-1:0]     bound;
   logic [PW-1:0]     wr_disc;

   assign status.qual = item_ff.applicable &&
      (CMP_IDX_W'(item_ff.action_index) < CMP_IDX_W'(MAX_ACTIONS));
   assign status.last_succ = item_ff.last_successor;
   assign status.last_act = item_ff.last_action;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_data = rsp_data_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      item_in = cmd.ld_item ? req_data : item_ff;
      prod_in = cmd.mul1 ? (MW'(item_ff.succ_prob) * MW'(item_ff.succ_value)) : prod_ff;

      // clamp discount above one
      wr_disc = csr_wdata[PW-1:0];
      discount_in = discount_ff;
      limit_in = limit_ff;
      if (csr_we && csr_index == bbmq_pkg::CSR_DISCOUNT) begin
         discount_in = (wr_disc > bbmq_pkg::ONE_Q16) ? bbmq_pkg::ONE_Q16 : wr_disc;
      end
      if (csr_we && csr_index == bbmq_pkg::CSR_DEAD_END_LIMIT) begin
         limit_in = csr_wdata[VW-1:0];
      end

      sum_ext = {1'b0, sum_ff} + (SW+1)'(prod_ff);
      mul2_full = MUL2_W'(sum_ff[SW-1:FW]) * MUL2_W'(discount_ff);
      scaled_in = cmd.mul2 ? mul2_full[MUL2_W-1:FW] : scaled_ff;
      q_full = {1'b0, scaled_ff} + (QW+1)'(item_ff.step_cost);
      q_capped = (q_full > (QW+1)'(limit_ff)) ? limit_ff : q_full[VW-1:0];

      sum_in = sum_ff;
      min_in = min_ff;
      min_act_in = min_act_ff;
      min_valid_in = min_valid_ff;
      any_appl_in = any_appl_ff;
      if (cmd.acc) begin
         any_appl_in = 1'b1;
         sum_in = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
      end
      if (cmd.qupd) begin
         sum_in = '0;
         if (!min_valid_ff || q_capped < min_ff) begin
            min_in = q_capped;
            min_act_in = item_ff.action_index;
            min_valid_in = 1'b1;
         end
      end
      if (cmd.emit) begin
         sum_in = '0;
         min_in = '1;
         min_act_in = '0;
         min_valid_in = 1'b0;
         any_appl_in = 1'b0;
      end

      if (item_ff.is_goal) begin
         bound = '0;
      end else if (limit_ff == '1) begin
         bound = '1;
      end else begin
         bound = limit_ff + VW'(1);
      end

      best_in = best_ff;
      best_act_in = best_act_ff;
      has_in = has_ff;
      dead_in = dead_ff;
      if (cmd.best) begin
         if (min_valid_ff && min_ff < bound) begin
            best_in = min_ff;
            best_act_in = min_act_ff;
            has_in = 1'b1;
            dead_in = !any_appl_ff && (min_ff >= limit_ff);
         end else begin
            best_in = bound;
            best_act_in = '0;
            has_in = 1'b0;
            dead_in = !any_appl_ff && (bound >= limit_ff);
         end
      end

      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_data_in.best_value = best_ff;
         rsp_data_in.best_action = best_act_ff;
         rsp_data_in.has_action = has_ff;
         rsp_data_in.dead_end = dead_ff;
         rsp_data_in.residual = (item_ff.old_value >= best_ff) ?
            (item_ff.old_value - best_ff) : (best_ff - item_ff.old_value);
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         discount_ff <= bbmq_pkg::DISCOUNT_RESET[PW-1:0];
         limit_ff <= bbmq_pkg::DEAD_END_LIMIT_RESET;
         sum_ff <= '0;
         min_ff <= '1;
         min_act_ff <= '0;
         min_valid_ff <= 1'b0;
         any_appl_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         discount_ff <= discount_in;
         limit_ff <= limit_in;
         sum_ff <= sum_in;
         min_ff <= min_in;
         min_act_ff <= min_act_in;
         min_valid_ff <= min_valid_in;
         any_appl_ff <= any_appl_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
      scaled_ff <= scaled_in;
      best_ff <= best_in;
      best_act_ff <= best_act_in;
      has_ff <= has_in;
      dead_ff <= dead_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: hdl/bellman_backup_min_q.sv
// Top level of the Bellman backup min-Q block: joins sequencer and datapath.
// Depends on bbmq_pkg, bbmq_ctrl and bbmq_dp.
//
// Streams one state's successor records (action by action) and returns one
// transaction per state at the item flagged last_action: the minimum
// Q-value (step cost plus discounted expected successor cost, capped at
// dead_end_limit), its action, a has_action flag, a dead-end mark and the
// residual against old_value. Values are unsigned Q16.16; probabilities and
// discount are Q1.16. Items whose action index is at or above MAX_ACTIONS
// count as placeholders. The block works on one item at a time, sequenced by a
// small state machine: each item is captured, probability times value is
// multiplied and, for an applicable item, added with saturation; an item
// closing an action then gets the discount multiply and the cost add with cap
// and minimum compare, and one closing the state gets bound selection and the
// result load, which waits while the result register is stalled. A finished
// result waits in the output register while the next item is taken in.
// Write discount and dead_end_limit only while no transaction is in flight.
module bellman_backup_min_q #(
   parameter int MAX_ACTIONS = bbmq_pkg::MAX_ACTIONS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bbmq_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bbmq_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [bbmq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bbmq_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // command and status between sequencer and datapath
   bbmq_pkg::cmd_type    cmd;
   bbmq_pkg::status_type status;

   // sequencer: accept one transaction, step it through the datapath
   bbmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: arithmetic, running minimum, configuration, result register
   bbmq_dp #(
      .MAX_ACTIONS (MAX_ACTIONS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: hdl/bbmq_checker.sv
// Port-level checks for the Bellman backup min-Q block, bound to its top.
// Depends on bbmq_pkg and bellman_backup_min_q.
module bbmq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bbmq_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one item at a time: stall right after an accepted transaction
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   // no result can appear in the cycle after an accept
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result too early");

   // no chosen action means action zero, and a dead end has no chosen action
   a_no_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_data.has_action || rsp_data.dead_end) |->
         rsp_data.best_action == '0 && !rsp_data.has_action)
      else $error("action field inconsistent");

endmodule

bind bellman_backup_min_q bbmq_checker u_bbmq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
